// ===== rtl/lljd_pkg.sv =====
// Shared types, codes and default sizes of the least-loaded job dispatcher.
package lljd_pkg;

    // Default build sizes.
    localparam int NUM_QUEUES_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes.
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SUBMIT = 2'd1;
    localparam logic [1:0] OP_FETCH  = 2'd2;
    localparam logic [1:0] OP_FINISH = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_BADQ  = 2'd3;

    // Configuration register indexes.
    localparam logic [2:0] CFG_QUEUE_COUNT     = 3'd0;
    localparam logic [2:0] CFG_CPU_QUEUE_COUNT = 3'd1;
    localparam logic [2:0] CFG_FINAL_ENABLE    = 3'd2;
    localparam logic [2:0] CFG_FINAL_ANY_QUEUE = 3'd3;
    localparam logic [2:0] CFG_FINAL_QUEUE     = 3'd4;
    localparam logic [2:0] CFG_FINAL_CODE      = 3'd5;
    localparam logic [2:0] CFG_FINAL_ARGUMENT  = 3'd6;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  queue_index;
        logic        any_queue;
        logic [15:0] job_code;
        logic [63:0] job_argument;
        logic        retry;
    } t_in;

    // Result transaction payload.
    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  chosen_queue;
        logic        job_valid;
        logic [15:0] out_job_code;
        logic [63:0] out_job_argument;
        logic        wake_valid;
        logic [5:0]  wake_queue;
        logic        backoff;
        logic        all_done;
        logic [15:0] outstanding;
    } t_out;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_in  item;
        logic need_scan;
    } t_cmd;

endpackage

// ===== rtl/lljd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lljd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== rtl/lljd_front.sv =====
// Front end: accepts input transactions, classifies them and buffers them.
module lljd_front
    import lljd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_final_any,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_cmd_pop
);
    t_cmd       r_buf [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;
    t_cmd       cls;

    assign o_in_ready  = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_buf[r_rp];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = i_cmd_pop && o_cmd_valid;

    // Mark the commands that need a least-loaded search before execution.
    always_comb begin
        cls.item      = i_in_data;
        cls.need_scan = ((i_in_data.operation == OP_SUBMIT) && i_in_data.any_queue)
                     || ((i_in_data.operation == OP_START) && i_final_any);
    end

    // Two-entry command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_buf[r_wp] <= cls;
                r_wp        <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== rtl/lljd_back.sv =====
// Back end: configuration, queue bookkeeping, job storage and result register.
module lljd_back
    import lljd_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_final_any,
    input  logic        i_cmd_valid,
    input  t_cmd        i_cmd,
    output logic        o_cmd_pop,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data
);
    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int AW = (NUM_QUEUES * QUEUE_DEPTH > 1) ? $clog2(NUM_QUEUES * QUEUE_DEPTH) : 1;
    localparam logic [FW-1:0] FULL_FILL = FW'(QUEUE_DEPTH);
    localparam logic [PW-1:0] LAST_PTR  = PW'(QUEUE_DEPTH - 1);
    localparam logic [6:0]    NQ7       = 7'(NUM_QUEUES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_READ = 2'd3;

    // Configuration registers.
    logic [6:0]  r_qcount;
    logic [6:0]  r_cpucount;
    logic        r_fen;
    logic        r_fany;
    logic [5:0]  r_fq;
    logic [15:0] r_fcode;
    logic [63:0] r_farg;

    // Dispatcher state.
    logic [PW-1:0] r_head [NUM_QUEUES];
    logic [PW-1:0] r_tail [NUM_QUEUES];
    logic [FW-1:0] r_fill [NUM_QUEUES];
    logic [15:0]   r_outst;
    logic          r_fcons;
    logic          r_started;
    logic          r_finished;
    logic [1:0]    r_state;
    t_in           r_cmd;
    logic [6:0]    r_idx;
    logic [6:0]    r_best;
    logic [FW-1:0] r_best_fill;
    logic          r_out_valid;
    t_out          r_out;

    logic [6:0]    n_use;
    logic [6:0]    n_ex;
    logic [6:0]    fixed_q;
    logic [6:0]    qi7;
    logic [FW-1:0] fill_qi;
    logic [FW-1:0] fill_best;
    logic [FW-1:0] fill_fixed;
    logic [FW-1:0] fill_idx;
    logic          out_free;
    logic          exec_fire;
    logic [15:0]   outst_inc;

    t_out          n_res;
    logic          n_push;
    logic [6:0]    n_pushq;
    logic [15:0]   n_pcode;
    logic [63:0]   n_parg;
    logic          n_pop;
    logic [15:0]   n_outst;
    logic          n_fcons;
    logic          n_started;
    logic          n_finished;
    logic          n_fetch;
    logic          lower;
    logic [6:0]    fin_q;
    logic [FW-1:0] fin_fill;
    logic [6:0]    st_q;
    logic [FW-1:0] st_fill;
    logic [6:0]    sub_q;
    logic [FW-1:0] sub_fill;

    logic [QW-1:0] pq;
    logic [QW-1:0] qx;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [79:0]   rdata;

    // Queues in use, queues examined, and the fixed final queue.
    always_comb begin
        if (r_qcount == 7'd0) begin
            n_use = 7'd1;
        end else if (r_qcount > NQ7) begin
            n_use = NQ7;
        end else begin
            n_use = r_qcount;
        end
        n_ex    = (r_cpucount != 7'd0) ? r_cpucount : n_use;
        if (n_ex > n_use) begin
            n_ex = n_use;
        end
        fixed_q = ({1'b0, r_fq} < n_use) ? {1'b0, r_fq} : 7'd0;
    end

    assign qi7        = {1'b0, r_cmd.queue_index};
    assign qx         = QW'(r_cmd.queue_index);
    assign fill_qi    = r_fill[qx];
    assign fill_best  = r_fill[QW'(r_best)];
    assign fill_fixed = r_fill[QW'(fixed_q)];
    assign fill_idx   = r_fill[QW'(r_idx)];
    assign out_free   = !r_out_valid || i_out_ready;
    assign exec_fire  = (r_state == S_EXEC) && out_free;
    assign outst_inc  = (r_outst == 16'hFFFF) ? r_outst : r_outst + 16'd1;
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_final_any = r_fany;

    assign st_q     = r_fany ? r_best : fixed_q;
    assign st_fill  = r_fany ? fill_best : fill_fixed;
    assign sub_q    = r_cmd.any_queue ? r_best : qi7;
    assign sub_fill = r_cmd.any_queue ? fill_best : fill_qi;
    assign fin_q    = r_fany ? qi7 : fixed_q;
    assign fin_fill = r_fany ? fill_qi : fill_fixed;

    // Execution step: decide result, queue updates and state changes.
    always_comb begin
        n_res      = '0;
        n_push     = 1'b0;
        n_pushq    = qi7;
        n_pcode    = r_cmd.job_code;
        n_parg     = r_cmd.job_argument;
        n_pop      = 1'b0;
        n_outst    = r_outst;
        n_fcons    = r_fcons;
        n_started  = r_started;
        n_finished = r_finished;
        n_fetch    = 1'b0;
        lower      = 1'b0;
        case (r_cmd.operation)
            OP_START: begin
                n_started = 1'b1;
                if (r_outst == 16'd0) begin
                    if (r_fen && !r_fcons) begin
                        n_fcons            = 1'b1;
                        n_res.chosen_queue = 6'(st_q);
                        n_pushq            = st_q;
                        n_pcode            = r_fcode;
                        n_parg             = r_farg;
                        if (st_fill < FULL_FILL) begin
                            n_push           = 1'b1;
                            n_outst          = outst_inc;
                            n_res.wake_valid = 1'b1;
                            n_res.wake_queue = 6'(st_q);
                        end else begin
                            n_res.status = ST_FULL;
                        end
                    end else begin
                        n_finished = 1'b1;
                    end
                end
            end
            OP_SUBMIT: begin
                n_res.chosen_queue = 6'(sub_q);
                n_pushq            = sub_q;
                if (sub_q >= n_use) begin
                    n_res.status = ST_BADQ;
                end else if (sub_fill >= FULL_FILL) begin
                    n_res.status = ST_FULL;
                end else begin
                    n_push     = 1'b1;
                    n_outst    = outst_inc;
                    n_finished = 1'b0;
                    if (r_started) begin
                        n_res.wake_valid = 1'b1;
                        n_res.wake_queue = 6'(sub_q);
                    end
                end
            end
            OP_FETCH: begin
                n_res.chosen_queue = r_cmd.queue_index;
                if (qi7 >= n_use) begin
                    n_res.status = ST_BADQ;
                end else if (fill_qi == '0) begin
                    n_res.status = ST_EMPTY;
                end else begin
                    n_pop           = 1'b1;
                    n_fetch         = 1'b1;
                    n_res.job_valid = 1'b1;
                end
            end
            default: begin
                n_res.chosen_queue = r_cmd.queue_index;
                if (qi7 >= n_use) begin
                    n_res.status = ST_BADQ;
                end else if (r_cmd.retry) begin
                    if (fill_qi < FULL_FILL) begin
                        n_push        = 1'b1;
                        n_res.backoff = (fill_qi == '0);
                    end else begin
                        n_res.status = ST_FULL;
                        lower        = 1'b1;
                    end
                end else begin
                    lower = 1'b1;
                end
                if (lower && (r_outst != 16'd0)) begin
                    n_outst = r_outst - 16'd1;
                    if (r_outst == 16'd1) begin
                        if (r_fen && !r_fcons) begin
                            n_fcons            = 1'b1;
                            n_res.chosen_queue = 6'(fin_q);
                            n_pushq            = fin_q;
                            n_pcode            = r_fcode;
                            n_parg             = r_farg;
                            if (fin_fill < FULL_FILL) begin
                                n_push  = 1'b1;
                                n_outst = 16'd1;
                                if (fin_q != qi7) begin
                                    n_res.wake_valid = 1'b1;
                                    n_res.wake_queue = 6'(fin_q);
                                end
                            end else begin
                                n_res.status = ST_FULL;
                            end
                        end else begin
                            n_finished = 1'b1;
                        end
                    end
                end
            end
        endcase
        n_res.all_done    = n_finished;
        n_res.outstanding = n_outst;
    end

    // Job storage addresses.
    assign pq    = QW'(n_pushq);
    assign waddr = AW'(int'(pq) * QUEUE_DEPTH + int'(r_tail[pq]));
    assign raddr = AW'(int'(qx) * QUEUE_DEPTH + int'(r_head[qx]));

    lljd_ram #(
        .WIDTH(80),
        .DEPTH(NUM_QUEUES * QUEUE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (exec_fire && n_push),
        .i_waddr(waddr),
        .i_wdata({n_pcode, n_parg}),
        .i_re   (exec_fire && n_pop),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Control sequencer, bookkeeping and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcount    <= 7'd1;
            r_cpucount  <= 7'd0;
            r_fen       <= 1'b0;
            r_fany      <= 1'b0;
            r_fq        <= 6'd0;
            r_fcode     <= 16'd0;
            r_farg      <= 64'd0;
            r_outst     <= 16'd0;
            r_fcons     <= 1'b0;
            r_started   <= 1'b0;
            r_finished  <= 1'b0;
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd       <= i_cmd.item;
                        r_idx       <= 7'd1;
                        r_best      <= 7'd0;
                        r_best_fill <= r_fill[0];
                        r_state     <= i_cmd.need_scan ? S_SCAN : S_EXEC;
                    end
                end
                S_SCAN: begin
                    if (r_idx >= n_ex) begin
                        r_state <= S_EXEC;
                    end else begin
                        if (fill_idx < r_best_fill) begin
                            r_best      <= r_idx;
                            r_best_fill <= fill_idx;
                        end
                        r_idx <= r_idx + 7'd1;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        r_out      <= n_res;
                        r_outst    <= n_outst;
                        r_fcons    <= n_fcons;
                        r_started  <= n_started;
                        r_finished <= n_finished;
                        if (n_push) begin
                            r_tail[pq] <= (r_tail[pq] == LAST_PTR) ? '0 : r_tail[pq] + 1'b1;
                            r_fill[pq] <= r_fill[pq] + 1'b1;
                        end
                        if (n_pop) begin
                            r_head[qx] <= (r_head[qx] == LAST_PTR) ? '0 : r_head[qx] + 1'b1;
                            r_fill[qx] <= r_fill[qx] - 1'b1;
                        end
                        if (n_fetch) begin
                            r_state <= S_READ;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_out.out_job_code     <= rdata[79:64];
                    r_out.out_job_argument <= rdata[63:0];
                    r_out_valid            <= 1'b1;
                    r_state                <= S_IDLE;
                end
            endcase
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_QUEUE_COUNT:     r_qcount   <= i_cfg_data[6:0];
                    CFG_CPU_QUEUE_COUNT: r_cpucount <= i_cfg_data[6:0];
                    CFG_FINAL_ENABLE: begin
                        r_fen   <= i_cfg_data[0];
                        r_fcons <= 1'b0;
                    end
                    CFG_FINAL_ANY_QUEUE: r_fany     <= i_cfg_data[0];
                    CFG_FINAL_QUEUE:     r_fq       <= i_cfg_data[5:0];
                    CFG_FINAL_CODE:      r_fcode    <= i_cfg_data[15:0];
                    CFG_FINAL_ARGUMENT:  r_farg     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== rtl/least_loaded_job_dispatcher.sv =====
// Top level of the least-loaded job dispatcher.
//
//  Channel   Direction  Handshake                      Payload
//  in        input      i_in_valid / o_in_ready        i_in_data   (t_in)
//  out       output     o_out_valid / i_out_ready      o_out_data  (t_out)
//  cfg       input      i_cfg_we                       i_cfg_index, i_cfg_data
//
// A two-entry command queue accepts one transaction per cycle until it is full.
// The back end takes each operation through an idle and an execute state, and
// a fetch also through a read state (registered job storage read). A choice of
// the least-loaded queue adds a scan state comparing fill counts one at a time.
// Reset is synchronous and active low; the job storage is not cleared.
// A stalled result holds the back end; the front keeps accepting until full.
module least_loaded_job_dispatcher
    import lljd_pkg::*;
#(
    parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;
    logic final_any;

    // Intake and classification.
    lljd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_final_any(final_any),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    // Execution of queue operations.
    lljd_back #(
        .NUM_QUEUES (NUM_QUEUES),
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_final_any(final_any),
        .i_cmd_valid(cmd_valid),
        .i_cmd      (cmd),
        .o_cmd_pop  (cmd_pop),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );
endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the least-loaded job dispatcher.
module tb_top;
    import lljd_pkg::*;

    localparam int NQ     = NUM_QUEUES_DEF;
    localparam int DEPTH  = QUEUE_DEPTH_DEF;
    localparam int LIMIT  = 400000;

    // Scoreboard: mirrors the dispatcher state and keeps the expected results.
    class dispatch_scoreboard;
        logic [6:0]  queue_count;
        logic [6:0]  cpu_queue_count;
        logic        final_enable;
        logic        final_any_queue;
        logic [5:0]  final_queue;
        logic [15:0] final_code;
        logic [63:0] final_argument;
        logic [15:0] codes [NQ][DEPTH];
        logic [63:0] args [NQ][DEPTH];
        int          head [NQ];
        int          tail [NQ];
        int          fill [NQ];
        int          outstanding_jobs;
        bit          final_consumed;
        bit          started;
        bit          finished;
        t_out        pending_results [$];
        int          error_count;

        function new();
            queue_count = 1;
            cpu_queue_count = 0;
            final_enable = 0;
            final_any_queue = 0;
            final_queue = 0;
            final_code = 0;
            final_argument = 0;
            for (int i = 0; i < NQ; i++) begin
                head[i] = 0;
                tail[i] = 0;
                fill[i] = 0;
            end
            outstanding_jobs = 0;
            final_consumed = 0;
            started = 0;
            finished = 0;
            error_count = 0;
        endfunction

        function void write_register(logic [2:0] index, logic [63:0] value);
            case (index)
                CFG_QUEUE_COUNT: queue_count = value[6:0];
                CFG_CPU_QUEUE_COUNT: cpu_queue_count = value[6:0];
                CFG_FINAL_ENABLE: begin
                    final_enable = value[0];
                    final_consumed = 0;
                end
                CFG_FINAL_ANY_QUEUE: final_any_queue = value[0];
                CFG_FINAL_QUEUE: final_queue = value[5:0];
                CFG_FINAL_CODE: final_code = value[15:0];
                CFG_FINAL_ARGUMENT: final_argument = value;
                default: ;
            endcase
        endfunction

        function int queues_in_use();
            if (queue_count == 0) return 1;
            if (queue_count > NQ) return NQ;
            return int'(queue_count);
        endfunction

        function int least_filled();
            int n;
            int ex;
            int best;
            n = queues_in_use();
            ex = (cpu_queue_count != 0) ? int'(cpu_queue_count) : n;
            best = 0;
            if (ex > n) ex = n;
            for (int i = 1; i < ex; i++)
                if (fill[i] < fill[best]) best = i;
            return best;
        endfunction

        function bit enqueue(int q, logic [15:0] code, logic [63:0] arg);
            if (fill[q] >= DEPTH) return 0;
            codes[q][tail[q]] = code;
            args[q][tail[q]] = arg;
            tail[q] = (tail[q] + 1) % DEPTH;
            fill[q]++;
            return 1;
        endfunction

        function void count_up();
            if (outstanding_jobs < 65535) outstanding_jobs++;
        endfunction

        function int fixed_final_queue();
            return (final_queue < queues_in_use()) ? int'(final_queue) : 0;
        endfunction

        // Work out the result of one accepted operation and queue it.
        function void note_operation(t_in op);
            t_out r;
            int n;
            int q;
            int qi;
            bit lower;
            r = '0;
            n = queues_in_use();
            qi = int'(op.queue_index);
            lower = 0;
            case (op.operation)
                OP_START: begin
                    started = 1;
                    if (outstanding_jobs == 0) begin
                        if (final_enable && !final_consumed) begin
                            q = final_any_queue ? least_filled() : fixed_final_queue();
                            final_consumed = 1;
                            r.chosen_queue = 6'(q);
                            if (enqueue(q, final_code, final_argument)) begin
                                count_up();
                                r.wake_valid = 1;
                                r.wake_queue = 6'(q);
                            end else begin
                                r.status = ST_FULL;
                            end
                        end else begin
                            finished = 1;
                        end
                    end
                end
                OP_SUBMIT: begin
                    q = op.any_queue ? least_filled() : qi;
                    r.chosen_queue = 6'(q);
                    if (q >= n) begin
                        r.status = ST_BADQ;
                    end else if (!enqueue(q, op.job_code, op.job_argument)) begin
                        r.status = ST_FULL;
                    end else begin
                        count_up();
                        finished = 0;
                        if (started) begin
                            r.wake_valid = 1;
                            r.wake_queue = 6'(q);
                        end
                    end
                end
                OP_FETCH: begin
                    r.chosen_queue = 6'(qi);
                    if (qi >= n) begin
                        r.status = ST_BADQ;
                    end else if (fill[qi] == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.job_valid = 1;
                        r.out_job_code = codes[qi][head[qi]];
                        r.out_job_argument = args[qi][head[qi]];
                        head[qi] = (head[qi] + 1) % DEPTH;
                        fill[qi]--;
                    end
                end
                default: begin
                    r.chosen_queue = 6'(qi);
                    if (qi >= n) begin
                        r.status = ST_BADQ;
                    end else if (op.retry) begin
                        if (enqueue(qi, op.job_code, op.job_argument)) begin
                            r.backoff = (fill[qi] == 1);
                        end else begin
                            r.status = ST_FULL;
                            lower = 1;
                        end
                    end else begin
                        lower = 1;
                    end
                    if (lower && outstanding_jobs != 0) begin
                        outstanding_jobs--;
                        if (outstanding_jobs == 0) begin
                            if (final_enable && !final_consumed) begin
                                q = final_any_queue ? qi : fixed_final_queue();
                                final_consumed = 1;
                                r.chosen_queue = 6'(q);
                                if (enqueue(q, final_code, final_argument)) begin
                                    count_up();
                                    if (q != qi) begin
                                        r.wake_valid = 1;
                                        r.wake_queue = 6'(q);
                                    end
                                end else begin
                                    r.status = ST_FULL;
                                end
                            end else begin
                                finished = 1;
                            end
                        end
                    end
                end
            endcase
            r.all_done = finished;
            r.outstanding = outstanding_jobs[15:0];
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            error_count++;
        endtask

        // Compare one result transaction with the oldest expectation.
        task check_result(t_out got);
            t_out exp_r;
            if (pending_results.size() == 0) begin
                report("result with no expectation");
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status) report("status");
            if (got.chosen_queue !== exp_r.chosen_queue) report("chosen_queue");
            if (got.job_valid !== exp_r.job_valid) report("job_valid");
            if (got.out_job_code !== exp_r.out_job_code) report("out_job_code");
            if (got.out_job_argument !== exp_r.out_job_argument) report("out_job_argument");
            if (got.wake_valid !== exp_r.wake_valid) report("wake_valid");
            if (got.wake_queue !== exp_r.wake_queue) report("wake_queue");
            if (got.backoff !== exp_r.backoff) report("backoff");
            if (got.all_done !== exp_r.all_done) report("all_done");
            if (got.outstanding !== exp_r.outstanding) report("outstanding");
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    dispatch_scoreboard sb;
    int  cycle_count;
    bit  idle_free;

    least_loaded_job_dispatcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // Clock generation.
    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Cycle limit watchdog.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, check every accepted result.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) sb.check_result(out_data);
        out_ready <= idle_free ? 1'b1 : ($urandom_range(99) >= 23);
    end

    // Send one operation and wait until it is accepted; valid stays up afterwards
    // so that the next transaction can follow without a gap.
    task automatic send_op(t_in op);
        if (!idle_free && $urandom_range(99) < 23) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 23) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= op;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_operation(op);
    endtask

    // Stop sending and wait until every expected result has come.
    task automatic hold_off();
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic drain();
        hold_off();
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [63:0] value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        sb.write_register(index, value);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in make_op(logic [1:0] opc, int q, int anyq, int rt);
        t_in op;
        op.operation = opc;
        op.queue_index = 6'(q);
        op.any_queue = 1'(anyq);
        op.job_code = 16'($urandom);
        op.job_argument = {$urandom, $urandom};
        op.retry = 1'(rt);
        return op;
    endfunction

    // Random operation, biased toward queues in use and toward submitting.
    function automatic t_in random_op();
        int pick;
        int q;
        pick = $urandom_range(99);
        q = ($urandom_range(9) == 0) ? $urandom_range(63)
                                     : $urandom_range(sb.queues_in_use() - 1);
        if (pick < 3) return make_op(OP_START, q, $urandom_range(1), $urandom_range(1));
        if (pick < 45) return make_op(OP_SUBMIT, q, $urandom_range(1), $urandom_range(1));
        if (pick < 75) return make_op(OP_FETCH, q, $urandom_range(1), $urandom_range(1));
        return make_op(OP_FINISH, q, $urandom_range(1), int'($urandom_range(2) == 0));
    endfunction

    initial begin
        t_in op;
        sb = new();
        cycle_count = 0;
        idle_free = 0;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        cfg_we = 0;
        cfg_index = CFG_QUEUE_COUNT;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset config, bad index, empty fetch, finish with nothing due.
        send_op(make_op(OP_FETCH, 0, 0, 0));
        send_op(make_op(OP_SUBMIT, 63, 0, 0));
        send_op(make_op(OP_FINISH, 0, 0, 0));
        send_op(make_op(OP_START, 0, 0, 0));
        drain();

        // Directed: final job armed to a fixed queue out of range, all queues.
        write_reg(CFG_QUEUE_COUNT, 64'd127);
        write_reg(CFG_CPU_QUEUE_COUNT, 64'd0);
        write_reg(CFG_FINAL_QUEUE, 64'd63);
        write_reg(CFG_FINAL_CODE, 64'hFFFF);
        write_reg(CFG_FINAL_ARGUMENT, '1);
        write_reg(CFG_FINAL_ANY_QUEUE, 64'd0);
        write_reg(CFG_FINAL_ENABLE, 64'd1);
        op = make_op(OP_SUBMIT, NQ - 1, 0, 0);
        op.job_code = '1;
        op.job_argument = '1;
        send_op(op);
        op.job_code = '0;
        op.job_argument = '0;
        op.any_queue = 1;
        send_op(op);
        send_op(make_op(OP_FETCH, NQ - 1, 0, 0));
        send_op(make_op(OP_FINISH, NQ - 1, 0, 1));
        send_op(make_op(OP_FINISH, 3, 0, 0));
        send_op(make_op(OP_FINISH, 3, 0, 0));
        send_op(make_op(OP_FETCH, 0, 0, 0));
        send_op(make_op(OP_FETCH, 0, 0, 0));
        send_op(make_op(OP_FINISH, 0, 0, 0));
        send_op(make_op(OP_START, 0, 0, 0));
        // Fill queue 2 past its depth, then retry into the full queue.
        for (int i = 0; i < DEPTH + 1; i++) send_op(make_op(OP_SUBMIT, 2, 0, 0));
        send_op(make_op(OP_FINISH, 2, 0, 1));
        drain();

        // Random phases across several register settings.
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_QUEUE_COUNT,
                      (phase == 0) ? 64'd0 : 64'($urandom_range(NQ + 2)));
            write_reg(CFG_CPU_QUEUE_COUNT,
                      (phase == 1) ? 64'd64 : 64'($urandom_range(NQ + 1)));
            write_reg(CFG_FINAL_ANY_QUEUE, 64'(phase % 2));
            write_reg(CFG_FINAL_QUEUE, 64'($urandom_range(NQ)));
            write_reg(CFG_FINAL_CODE, 64'($urandom));
            write_reg(CFG_FINAL_ARGUMENT, {$urandom, $urandom});
            write_reg(CFG_FINAL_ENABLE, 64'($urandom_range(3) != 0));
            idle_free = (phase == 2);
            for (int i = 0; i < 150; i++) begin
                send_op(random_op());
                // Sender holds off until every result has come back.
                if (i == 75) hold_off();
            end
            idle_free = 0;
            drain();
        end

        if (sb.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
